// ===== src/mpfe_pkg.sv =====
// Shared constants and types for the monochrome page frame store engine.
package mpfe_pkg;
	localparam int unsigned COLUMNS_DEF = 128;
	localparam int unsigned PAGES_DEF = 8;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_LINE = 2'd1,
		OP_FILL = 2'd2,
		OP_REFRESH = 2'd3
	} op_t;

	localparam logic [1:0] PEN_OFF = 2'd0;
	localparam logic [1:0] PEN_SET = 2'd1;
	localparam logic [1:0] PEN_INVERT = 2'd2;
	localparam logic [1:0] PEN_NONE = 2'd3;

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_HIGH = 8'h10;
	localparam logic [7:0] CMD_COL_LOW = 8'h00;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] pen;
		logic [7:0] x_start;
		logic [7:0] y_start;
		logic [7:0] x_end;
		logic [7:0] y_end;
		logic [2:0] page_sel;
	} req_t;

	typedef struct packed {
		logic        is_data;
		logic [63:0] payload;
		logic [3:0]  byte_count;
		logic        last;
	} rsp_t;

	// Divider handshake between the sequencer and the rounding divider.
	typedef struct packed {
		logic        start;
		logic [16:0] num;
		logic [8:0]  den;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [8:0] quot;
	} div_rsp_t;
endpackage

// ===== src/mpfe_if.sv =====
// Valid/ready channel interface carrying one packed request or result.
interface mpfe_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/mpfe_ram.sv =====
// Generic single-port RAM with registered read.
module mpfe_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== src/mpfe_div.sv =====
// Shared restoring divider: rounds num/den half away from zero, one bit a cycle.
module mpfe_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mpfe_pkg::div_req_t      req,
	output mpfe_pkg::div_rsp_t      rsp
);
	// Unsigned quotient of (2n + d) / (2d), sign applied at the end.
	logic [17:0] rem_q;
	logic [17:0] dvd_q;
	logic [9:0]  dvs_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] abs_n;
	logic        neg_n;
	logic [18:0] trial;
	logic [17:0] rem_sh;
	logic [8:0]  q_mag;

	assign neg_n = req.num[16];
	assign abs_n = neg_n ? (17'd0 - req.num) : req.num;
	assign rem_sh = {rem_q[16:0], dvd_q[17]};
	assign trial = {1'b0, rem_sh} - {9'd0, dvs_q};
	assign q_mag = dvd_q[8:0];
	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? (9'd0 - q_mag) : q_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			dvd_q <= '0;
			dvs_q <= '0;
			neg_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd18;
				rem_q <= '0;
				dvd_q <= {abs_n, 1'b0} + {9'd0, req.den};
				dvs_q <= {req.den, 1'b0};
				neg_q <= neg_n;
			end else if (busy_q) begin
				if (!trial[18]) begin
					rem_q <= trial[17:0];
				end else begin
					rem_q <= rem_sh;
				end
				dvd_q <= {dvd_q[16:0], ~trial[18]};
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== src/mono_page_framebuffer_engine.sv =====
// Top level of the monochrome page frame store engine.
// A pixel command is accepted, read and then modify-written through the single
// frame store port; a line runs those read and modify-write steps for each column
// or row it walks, and each sloped column first passes through the shared
// bit-serial divider. A fill walks all COLUMNS*PAGES bytes, one per cycle for
// clear and set, with a read and a write per byte for invert. A refresh emits one
// command result and ceil(COLUMNS/8) data results of up to eight store reads each,
// and waits for each result to be taken before emitting the next. After reset a
// clearing pass writes all COLUMNS*PAGES bytes before the first request is taken.
module mono_page_framebuffer_engine #(
	parameter int unsigned COLUMNS = mpfe_pkg::COLUMNS_DEF,
	parameter int unsigned PAGES = mpfe_pkg::PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mpfe_if.sink   req,
	mpfe_if.source rsp
);
	localparam int unsigned DEPTH = COLUMNS * PAGES;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned ROWS = PAGES * 8;
	localparam int unsigned GROUPS = (COLUMNS + 7) / 8;
	localparam int unsigned GW = $clog2(GROUPS + 1);
	localparam int unsigned LAST_N = COLUMNS - (GROUPS - 1) * 8;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PIX_RD, S_PIX_WR, S_LINE, S_DIV, S_FILL_RD, S_FILL_WR,
		S_REF_CMD, S_REF_RD, S_REF_CAP, S_REF_OUT
	} state_t;

	state_t state_q;
	mpfe_pkg::req_t r_q;
	logic [8:0]  cur_q;
	logic [8:0]  hi_q;
	logic [8:0]  px_q;
	logic [8:0]  py_q;
	logic [AW:0] addr_q;
	logic [2:0]  lane_q;
	logic [GW-1:0] grp_q;
	logic [63:0] pay_q;
	logic        rsp_v_q;
	mpfe_pkg::rsp_t out_q;
	logic        ret_line_q;

	logic        we;
	logic [AW-1:0] ram_addr;
	logic [7:0]  wdata;
	logic [7:0]  rdata;
	mpfe_pkg::div_req_t dreq;
	mpfe_pkg::div_rsp_t drsp;

	logic [8:0]  xs9, xe9, ys9, ye9;
	logic signed [9:0] dxs, dys, offs;
	logic signed [19:0] prod;
	logic [8:0]  pix_y;
	logic        in_range;
	logic [AW-1:0] pix_addr;
	logic [7:0]  bitmask;
	logic [AW-1:0] ref_addr;
	logic [8:0]  col;

	assign xs9 = {1'b0, r_q.x_start};
	assign xe9 = {1'b0, r_q.x_end};
	assign ys9 = {1'b0, r_q.y_start};
	assign ye9 = {1'b0, r_q.y_end};
	assign dxs = $signed({1'b0, xe9}) - $signed({1'b0, xs9});
	assign dys = $signed({1'b0, ye9}) - $signed({1'b0, ys9});
	assign offs = $signed({1'b0, cur_q}) - $signed({1'b0, xs9});
	assign prod = dys * offs;
	assign dreq.start = (state_q == S_LINE) && (r_q.y_start != r_q.y_end)
		&& (r_q.x_start != r_q.x_end) && (cur_q <= hi_q);
	assign dreq.num = prod[16:0];
	assign dreq.den = dxs[9] ? (9'd0 - dxs[8:0]) : dxs[8:0];
	assign pix_y = ys9 + (dxs[9] ? (9'd0 - drsp.quot) : drsp.quot);

	assign in_range = (px_q < 9'(COLUMNS)) && (py_q < 9'(ROWS));
	assign pix_addr = AW'(px_q) * AW'(PAGES) + AW'(py_q >> 3);
	assign bitmask = 8'd1 << py_q[2:0];
	assign col = 9'({grp_q, lane_q});
	assign ref_addr = AW'(col) * AW'(PAGES) + AW'(r_q.page_sel);

	always_comb begin
		we = 1'b0;
		wdata = 8'h00;
		ram_addr = addr_q[AW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_PIX_RD: begin
				ram_addr = pix_addr;
			end
			S_PIX_WR: begin
				ram_addr = pix_addr;
				we = in_range && (r_q.pen != mpfe_pkg::PEN_NONE);
				unique case (r_q.pen)
					mpfe_pkg::PEN_OFF: wdata = rdata & ~bitmask;
					mpfe_pkg::PEN_SET: wdata = rdata | bitmask;
					default: wdata = rdata ^ bitmask;
				endcase
			end
			S_FILL_RD: begin
				we = (r_q.pen == mpfe_pkg::PEN_OFF) || (r_q.pen == mpfe_pkg::PEN_SET);
				wdata = (r_q.pen == mpfe_pkg::PEN_SET) ? 8'hFF : 8'h00;
			end
			S_FILL_WR: begin
				we = 1'b1;
				wdata = ~rdata;
			end
			S_REF_RD: begin
				ram_addr = ref_addr;
			end
			default: begin
			end
		endcase
	end

	mpfe_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
	);

	mpfe_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_v_q;
	assign rsp.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q <= '0;
			rsp_v_q <= 1'b0;
			r_q <= '0;
			cur_q <= '0;
			hi_q <= '0;
			px_q <= '0;
			py_q <= '0;
			lane_q <= '0;
			grp_q <= '0;
			pay_q <= '0;
			out_q <= '0;
			ret_line_q <= 1'b0;
		end else begin
			if (rsp_v_q && rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == (AW+1)'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						r_q <= req.data;
						px_q <= {1'b0, req.data.x_start};
						py_q <= {1'b0, req.data.y_start};
						ret_line_q <= 1'b0;
						addr_q <= '0;
						lane_q <= '0;
						grp_q <= '0;
						pay_q <= '0;
						unique case (mpfe_pkg::op_t'(req.data.op))
							mpfe_pkg::OP_PIXEL: state_q <= S_PIX_RD;
							mpfe_pkg::OP_LINE: begin
								state_q <= S_LINE;
								if (req.data.y_start == req.data.y_end) begin
									cur_q <= {1'b0, (req.data.x_start < req.data.x_end)
										? req.data.x_start : req.data.x_end};
									hi_q <= {1'b0, (req.data.x_start < req.data.x_end)
										? req.data.x_end : req.data.x_start};
								end else if (req.data.x_start == req.data.x_end) begin
									cur_q <= {1'b0, (req.data.y_start < req.data.y_end)
										? req.data.y_start : req.data.y_end};
									hi_q <= {1'b0, (req.data.y_start < req.data.y_end)
										? req.data.y_end : req.data.y_start};
								end else begin
									cur_q <= {1'b0, (req.data.x_start < req.data.x_end)
										? req.data.x_start : req.data.x_end};
									hi_q <= {1'b0, (req.data.x_start < req.data.x_end)
										? req.data.x_end : req.data.x_start};
								end
							end
							mpfe_pkg::OP_FILL: state_q <= S_FILL_RD;
							default: begin
								if (32'(req.data.page_sel) < PAGES) begin
									state_q <= S_REF_CMD;
								end
							end
						endcase
					end
				end
				S_PIX_RD: state_q <= S_PIX_WR;
				S_PIX_WR: state_q <= ret_line_q ? S_LINE : S_IDLE;
				S_LINE: begin
					if (cur_q > hi_q) begin
						state_q <= S_IDLE;
					end else begin
						cur_q <= cur_q + 9'd1;
						ret_line_q <= 1'b1;
						if (r_q.y_start == r_q.y_end) begin
							px_q <= cur_q;
							py_q <= ys9;
							state_q <= S_PIX_RD;
						end else if (r_q.x_start == r_q.x_end) begin
							px_q <= xs9;
							py_q <= cur_q;
							state_q <= S_PIX_RD;
						end else begin
							px_q <= cur_q;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						// Negative rows are skipped; 9-bit wrap lands above ROWS.
						py_q <= pix_y;
						state_q <= S_PIX_RD;
					end
				end
				S_FILL_RD: begin
					if (r_q.pen == mpfe_pkg::PEN_INVERT) begin
						state_q <= S_FILL_WR;
					end else if (addr_q == (AW+1)'(DEPTH - 1)
						|| r_q.pen == mpfe_pkg::PEN_NONE) begin
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_FILL_WR: begin
					if (addr_q == (AW+1)'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
						state_q <= S_FILL_RD;
					end
				end
				S_REF_CMD: begin
					if (!rsp_v_q) begin
						rsp_v_q <= 1'b1;
						out_q.is_data <= 1'b0;
						out_q.payload <= {40'd0, mpfe_pkg::CMD_COL_LOW, mpfe_pkg::CMD_COL_HIGH,
							mpfe_pkg::CMD_PAGE_BASE + 8'(r_q.page_sel)};
						out_q.byte_count <= 4'd3;
						out_q.last <= 1'b0;
						state_q <= S_REF_RD;
					end
				end
				S_REF_RD: state_q <= S_REF_CAP;
				S_REF_CAP: begin
					pay_q[lane_q*8 +: 8] <= rdata;
					if (lane_q == 3'd7 || col == 9'(COLUMNS - 1)) begin
						state_q <= S_REF_OUT;
					end else begin
						lane_q <= lane_q + 3'd1;
						state_q <= S_REF_RD;
					end
				end
				S_REF_OUT: begin
					if (!rsp_v_q) begin
						rsp_v_q <= 1'b1;
						out_q.is_data <= 1'b1;
						out_q.payload <= pay_q;
						out_q.last <= (grp_q == GW'(GROUPS - 1));
						out_q.byte_count <= (grp_q == GW'(GROUPS - 1)) ? 4'(LAST_N) : 4'd8;
						pay_q <= '0;
						lane_q <= '0;
						grp_q <= grp_q + 1'b1;
						state_q <= (grp_q == GW'(GROUPS - 1)) ? S_IDLE : S_REF_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sim/mono_page_framebuffer_engine_test.sv =====
// Self-checking testbench for the monochrome page frame store engine.
module mono_page_framebuffer_engine_test;
	import mpfe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCOL = 128;
	localparam int NPAGE = 8;
	localparam int WATCHDOG = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mpfe_if #(.T(req_t)) req_ch ();
	mpfe_if #(.T(rsp_t)) rsp_ch ();

	mono_page_framebuffer_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [7:0] shadow_store [NCOL*NPAGE];
	req_t pending_reqs [$];
	rsp_t expected_bytes [$];
	int errors = 0;
	int idle_cycles = 0;
	int hold_off = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit req_taken = 0;

	function automatic int short_or_long_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void plot(int x, int y, logic [1:0] pen);
		int idx;
		if (x < 0 || y < 0 || x >= NCOL || y >= NPAGE * 8)
			return;
		idx = x * NPAGE + y / 8;
		case (pen)
			PEN_OFF: shadow_store[idx][y % 8] = 1'b0;
			PEN_SET: shadow_store[idx][y % 8] = 1'b1;
			PEN_INVERT: shadow_store[idx][y % 8] = ~shadow_store[idx][y % 8];
			default: ;
		endcase
	endfunction

	function automatic int round_div(int n, int d);
		int q;
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		if (n < 0) begin
			q = (2 * (-n) + d) / (2 * d);
			return -q;
		end
		return (2 * n + d) / (2 * d);
	endfunction

	function automatic void predict(req_t r);
		int lo, hi, y;
		rsp_t res;
		case (op_t'(r.op))
			OP_PIXEL: plot(r.x_start, r.y_start, r.pen);
			OP_LINE: begin
				lo = (r.x_start < r.x_end) ? r.x_start : r.x_end;
				hi = (r.x_start < r.x_end) ? r.x_end : r.x_start;
				if (r.y_start == r.y_end) begin
					for (int c = lo; c <= hi; c++)
						plot(c, r.y_start, r.pen);
				end else if (r.x_start == r.x_end) begin
					lo = (r.y_start < r.y_end) ? r.y_start : r.y_end;
					hi = (r.y_start < r.y_end) ? r.y_end : r.y_start;
					for (int c = lo; c <= hi; c++)
						plot(r.x_start, c, r.pen);
				end else begin
					for (int c = lo; c <= hi; c++) begin
						y = int'(r.y_start) + round_div((int'(r.y_end) - int'(r.y_start))
							* (c - int'(r.x_start)), int'(r.x_end) - int'(r.x_start));
						plot(c, y, r.pen);
					end
				end
			end
			OP_FILL: begin
				for (int i = 0; i < NCOL * NPAGE; i++) begin
					case (r.pen)
						PEN_OFF: shadow_store[i] = 8'h00;
						PEN_SET: shadow_store[i] = 8'hFF;
						PEN_INVERT: shadow_store[i] = ~shadow_store[i];
						default: ;
					endcase
				end
			end
			OP_REFRESH: begin
				if (r.page_sel < NPAGE) begin
					res = '0;
					res.payload[7:0] = CMD_PAGE_BASE + r.page_sel;
					res.payload[15:8] = CMD_COL_HIGH;
					res.payload[23:16] = CMD_COL_LOW;
					res.byte_count = 4'd3;
					expected_bytes.push_back(res);
					for (int k = 0; k < (NCOL + 7) / 8; k++) begin
						res = '0;
						res.is_data = 1'b1;
						for (int i = 0; i < 8 && k * 8 + i < NCOL; i++) begin
							res.payload[8*i +: 8] = shadow_store[(k*8 + i) * NPAGE + r.page_sel];
							res.byte_count = res.byte_count + 4'd1;
						end
						res.last = (k == (NCOL + 7) / 8 - 1);
						expected_bytes.push_back(res);
					end
				end
			end
		endcase
	endfunction

	function automatic req_t random_req();
		req_t r;
		int sel;
		r.op = 2'($urandom_range(0, 3));
		r.pen = ($urandom_range(0, 19) == 0) ? PEN_NONE : 2'($urandom_range(0, 2));
		sel = $urandom_range(0, 9);
		r.x_start = (sel == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
		r.y_start = (sel == 1) ? 8'($urandom) : 8'($urandom_range(0, 63));
		r.x_end = (sel == 2) ? 8'($urandom) : 8'($urandom_range(0, 127));
		r.y_end = (sel == 3) ? 8'($urandom) : 8'($urandom_range(0, 63));
		r.page_sel = 3'($urandom);
		if (r.op == OP_FILL && $urandom_range(0, 2) != 0)
			r.op = OP_PIXEL;
		if (r.op == OP_LINE && $urandom_range(0, 3) == 0)
			r.y_end = r.y_start;
		if (r.op == OP_LINE && $urandom_range(0, 3) == 0)
			r.x_end = r.x_start;
		return r;
	endfunction

	function automatic req_t make_req(op_t op, logic [1:0] pen, int xs, int ys, int xe, int ye,
		int pg);
		req_t r;
		r.op = op;
		r.pen = pen;
		r.x_start = 8'(xs);
		r.y_start = 8'(ys);
		r.x_end = 8'(xe);
		r.y_end = 8'(ye);
		r.page_sel = 3'(pg);
		return r;
	endfunction

	// Driver: offers queued requests with random gaps, moving on once one is accepted.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
		end else begin
			if (req_taken) begin
				req_taken = 1'b0;
				void'(pending_reqs.pop_front());
				send_gap = short_or_long_gap();
			end
			if (send_gap > 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req_ch.valid <= 1'b1;
				req_ch.data <= pending_reqs[0];
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver readiness, including one long forced hold-off.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off--;
			rsp_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			rsp_ch.ready <= 1'b0;
		end else begin
			recv_gap = short_or_long_gap();
			rsp_ch.ready <= 1'b1;
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (req_ch.valid && req_ch.ready) begin
				predict(req_ch.data);
				req_taken = 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, rsp_ch.data);
					errors++;
				end else begin
					if (rsp_ch.data.is_data !== expected_bytes[0].is_data) begin
						$display("%0t: is_data expected %b actual %b", $realtime,
							expected_bytes[0].is_data, rsp_ch.data.is_data);
						errors++;
					end
					if (rsp_ch.data.payload !== expected_bytes[0].payload) begin
						$display("%0t: payload expected %h actual %h", $realtime,
							expected_bytes[0].payload, rsp_ch.data.payload);
						errors++;
					end
					if (rsp_ch.data.byte_count !== expected_bytes[0].byte_count) begin
						$display("%0t: byte_count expected %0d actual %0d", $realtime,
							expected_bytes[0].byte_count, rsp_ch.data.byte_count);
						errors++;
					end
					if (rsp_ch.data.last !== expected_bytes[0].last) begin
						$display("%0t: last expected %b actual %b", $realtime,
							expected_bytes[0].last, rsp_ch.data.last);
						errors++;
					end
					void'(expected_bytes.pop_front());
				end
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("mono_page_framebuffer_engine_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NCOL * NPAGE; i++)
			shadow_store[i] = 8'h00;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_reqs.push_back(make_req(OP_REFRESH, PEN_OFF, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PIXEL, PEN_SET, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PIXEL, PEN_SET, 127, 63, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PIXEL, PEN_SET, 128, 5, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PIXEL, PEN_SET, 5, 64, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PIXEL, PEN_SET, 255, 255, 255, 255, 7));
		pending_reqs.push_back(make_req(OP_PIXEL, PEN_INVERT, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PIXEL, PEN_NONE, 3, 3, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_LINE, PEN_SET, 0, 10, 255, 10, 0));
		pending_reqs.push_back(make_req(OP_LINE, PEN_SET, 20, 255, 20, 0, 0));
		pending_reqs.push_back(make_req(OP_LINE, PEN_INVERT, 0, 0, 127, 63, 0));
		pending_reqs.push_back(make_req(OP_LINE, PEN_SET, 100, 63, 2, 0, 0));
		pending_reqs.push_back(make_req(OP_LINE, PEN_SET, 0, 3, 2, 4, 0));
		pending_reqs.push_back(make_req(OP_LINE, PEN_SET, 255, 0, 0, 255, 0));
		pending_reqs.push_back(make_req(OP_LINE, PEN_SET, 255, 255, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_LINE, PEN_OFF, 10, 60, 40, 0, 0));
		pending_reqs.push_back(make_req(OP_REFRESH, PEN_OFF, 0, 0, 0, 0, 7));
		pending_reqs.push_back(make_req(OP_REFRESH, PEN_OFF, 0, 0, 0, 0, 1));
		pending_reqs.push_back(make_req(OP_REFRESH, PEN_OFF, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_FILL, PEN_SET, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_FILL, PEN_NONE, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_REFRESH, PEN_OFF, 0, 0, 0, 0, 3));
		pending_reqs.push_back(make_req(OP_FILL, PEN_INVERT, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_PIXEL, PEN_SET, 64, 32, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_REFRESH, PEN_OFF, 0, 0, 0, 0, 4));
		pending_reqs.push_back(make_req(OP_FILL, PEN_OFF, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(OP_REFRESH, PEN_OFF, 0, 0, 0, 0, 0));

		for (int i = 0; i < 240; i++) begin
			if (i == 60) begin
				wait (pending_reqs.size() == 0 && expected_bytes.size() == 0);
				@(negedge clk);
				hold_off = 600;
				for (int j = 0; j < 6; j++)
					pending_reqs.push_back(make_req(OP_REFRESH, PEN_OFF, 0, 0, 0, 0, j));
			end
			pending_reqs.push_back(random_req());
		end
		wait (pending_reqs.size() == 0 && expected_bytes.size() == 0);
		repeat (2000) @(posedge clk);
		if (errors == 0 && expected_bytes.size() == 0)
			$display("mono_page_framebuffer_engine_test: done, clean");
		else
			$display("mono_page_framebuffer_engine_test: done, errors");
		$finish;
	end
endmodule

// ===== files.f =====
src/mpfe_pkg.sv
src/mpfe_if.sv
src/mpfe_ram.sv
src/mpfe_div.sv
src/mono_page_framebuffer_engine.sv
sim/mono_page_framebuffer_engine_test.sv
